FILE: hw/rtl/hit_split_timer_assert.svh
// Assertion macros shared by the split timer RTL.
`ifndef HIT_SPLIT_TIMER_ASSERT_SVH
`define HIT_SPLIT_TIMER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define HST_ASSERT_HOLDS(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hit_split_timer: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define HST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hit_split_timer: next-cycle check failed");

`endif

FILE: hw/rtl/hst_pkg.sv
// Types, codes and constants of the split timer.
package hst_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int TIME_W         = 16;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_IDX_W      = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_TICKS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ELAPSED  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd4;

	// Register reset values
	localparam logic [7:0]  BLANK_TICKS_RST  = 8'd10;
	localparam logic [15:0] IDLE_LIMIT_RST   = 16'd30000;
	localparam logic [15:0] MIN_ELAPSED_RST  = 16'd60;
	localparam logic [3:0]  MAX_HITS_RST     = 4'd9;
	localparam logic [7:0]  BLINK_PERIOD_RST = 8'd50;

	localparam logic [3:0]  HITS_CAP     = 4'd9;
	localparam logic [7:0]  HIST_IDLE    = 8'hff;
	localparam logic [7:0]  HIST_PRESSED = 8'h01;

	// End causes
	localparam logic [2:0] END_RUNNING   = 3'd0;
	localparam logic [2:0] END_HIT_LIMIT = 3'd1;
	localparam logic [2:0] END_IDLE      = 3'd2;
	localparam logic [2:0] END_START     = 3'd3;
	localparam logic [2:0] END_FORWARD   = 3'd4;

	typedef struct packed {
		logic [7:0]  blank_ticks;
		logic [15:0] idle_limit;
		logic [15:0] min_elapsed;
		logic [3:0]  max_hits;
		logic [7:0]  blink_period;
	} cfg_t;

	typedef struct packed {
		logic start_run;
		logic tick;
		logic sensor_edge;
		logic start_pressed;
		logic forward_pressed;
	} item_t;

	typedef struct packed {
		logic              hit_valid;
		logic [3:0]        hit_number;
		logic [TIME_W-1:0] hit_time;
		logic [TIME_W-1:0] elapsed_ticks;
		logic              dot_lit;
		logic [2:0]        end_cause;
	} res_t;

endpackage

FILE: hw/rtl/hit_split_timer.sv
// Top level of the split timer: input register, run engine and result register.
`include "hit_split_timer_assert.svh"

// Split timer for sensor hits. Every input item gives exactly one result
// item. An item is registered in the input register on entry and its result
// in the result register when the item steps on, so a result is on the
// outputs once its item has passed both registers. One item is taken every
// cycle while the receiver does not stall, set by the combinational update
// of the run state between the two registers. The input register keeps
// accepting while a finished result waits to be taken, and stall back to the
// source rises only when both registers hold an item and the receiver stalls.
// Configuration writes are expected only while no item is in flight;
// idle_limit and blink_period are picked up at reset or at start_run.
module hit_split_timer import hst_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  start_run,
	input  logic                  tick,
	input  logic                  sensor_edge,
	input  logic                  start_pressed,
	input  logic                  forward_pressed,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit_valid,
	output logic [3:0]            hit_number,
	output logic [TIME_W-1:0]     hit_time,
	output logic [TIME_W-1:0]     elapsed_ticks,
	output logic                  dot_lit,
	output logic [2:0]            end_cause
);

	cfg_t  cfg;
	item_t item_s1;
	res_t  res, res_s2;
	logic  valid_s1, valid_s2, advance, step, in_take;

	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	hst_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hst_engine #(
		.COUNT_BITS (COUNT_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
			valid_s2 <= step || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.start_run       <= start_run;
			item_s1.tick            <= tick;
			item_s1.sensor_edge     <= sensor_edge;
			item_s1.start_pressed   <= start_pressed;
			item_s1.forward_pressed <= forward_pressed;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign hit_valid     = res_s2.hit_valid;
	assign hit_number    = res_s2.hit_number;
	assign hit_time      = res_s2.hit_time;
	assign elapsed_ticks = res_s2.elapsed_ticks;
	assign dot_lit       = res_s2.dot_lit;
	assign end_cause     = res_s2.end_cause;

	`HST_ASSERT_NEXT(a_take_fills_s1, in_take, valid_s1)
	`HST_ASSERT_HOLDS(a_stall_only_full, in_stall, valid_s1 && valid_s2)
	`HST_ASSERT_HOLDS(a_hit_numbered, valid_s2 && hit_valid, hit_number != 4'd0 && hit_number <= HITS_CAP)
	`HST_ASSERT_HOLDS(a_no_hit_zero, valid_s2 && !hit_valid, hit_number == 4'd0 && hit_time == '0)

endmodule

FILE: hw/rtl/hst_cfg.sv
// Configuration registers of the split timer.
module hst_cfg import hst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blank_ticks  <= BLANK_TICKS_RST;
			cfg_q.idle_limit   <= IDLE_LIMIT_RST;
			cfg_q.min_elapsed  <= MIN_ELAPSED_RST;
			cfg_q.max_hits     <= MAX_HITS_RST;
			cfg_q.blink_period <= BLINK_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLANK_TICKS:  cfg_q.blank_ticks  <= cfg_data[7:0];
				REG_IDLE_LIMIT:   cfg_q.idle_limit   <= cfg_data[15:0];
				REG_MIN_ELAPSED:  cfg_q.min_elapsed  <= cfg_data[15:0];
				REG_MAX_HITS:     cfg_q.max_hits     <= cfg_data[3:0];
				REG_BLINK_PERIOD: cfg_q.blink_period <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/hst_engine.sv
// Run state of the split timer and its combinational update.
module hst_engine import hst_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  step,
	input  item_t item,
	output res_t  res
);

	localparam int CMP_W = (COUNT_BITS > TIME_W) ? COUNT_BITS : TIME_W;

	logic [COUNT_BITS-1:0] el_q, el_b, el_n, el_inc;
	logic [3:0]  hc_q, hc_b, hc_n, hc_inc, limit;
	logic [7:0]  bl_q, bl_b, bl_n;
	logic [15:0] il_q, il_b, il_n, il_dec;
	logic [7:0]  bk_q, bk_b, bk_n, bk_dec;
	logic        dot_q, dot_b, dot_n;
	logic [7:0]  sh_q, sh_b, sh_n, sh_shift;
	logic [7:0]  fh_q, fh_b, fh_n, fh_shift;
	logic [2:0]  ec_q, ec_b, ec_n;
	logic [CMP_W-1:0] el_b_wide, el_inc_wide, el_n_wide;
	logic        hit, start_det, fwd_det, stop_ok;

	// A new run starts from the cleared state, taken from the live registers.
	always_comb begin
		if (item.start_run) begin
			el_b  = '0;
			hc_b  = '0;
			bl_b  = '0;
			il_b  = cfg.idle_limit;
			bk_b  = cfg.blink_period;
			dot_b = 1'b1;
			sh_b  = HIST_IDLE;
			fh_b  = HIST_IDLE;
			ec_b  = END_RUNNING;
		end else begin
			el_b  = el_q;
			hc_b  = hc_q;
			bl_b  = bl_q;
			il_b  = il_q;
			bk_b  = bk_q;
			dot_b = dot_q;
			sh_b  = sh_q;
			fh_b  = fh_q;
			ec_b  = ec_q;
		end
	end

	always_comb begin
		if (cfg.max_hits == 4'd0) begin
			limit = 4'd1;
		end else if (cfg.max_hits > HITS_CAP) begin
			limit = HITS_CAP;
		end else begin
			limit = cfg.max_hits;
		end
	end

	assign hc_inc      = hc_b + 4'd1;
	assign el_inc      = el_b + 1'b1;
	assign il_dec      = il_b - 16'd1;
	assign bk_dec      = bk_b - 8'd1;
	assign sh_shift    = {sh_b[6:0], item.start_pressed};
	assign fh_shift    = {fh_b[6:0], item.forward_pressed};
	assign el_b_wide   = CMP_W'(el_b);
	assign el_inc_wide = CMP_W'(el_inc);
	assign el_n_wide   = CMP_W'(el_n);
	assign hit         = item.sensor_edge && (bl_b == 8'd0);
	assign start_det   = (sh_shift == HIST_PRESSED);
	assign fwd_det     = (fh_shift == HIST_PRESSED);
	assign stop_ok     = el_inc_wide > CMP_W'(cfg.min_elapsed);

	always_comb begin
		el_n  = el_b;
		hc_n  = hc_b;
		bl_n  = bl_b;
		il_n  = il_b;
		bk_n  = bk_b;
		dot_n = dot_b;
		sh_n  = sh_b;
		fh_n  = fh_b;
		ec_n  = ec_b;
		res.hit_valid  = 1'b0;
		res.hit_number = 4'd0;
		res.hit_time   = '0;
		if (ec_b == END_RUNNING) begin
			if (hit) begin
				hc_n           = hc_inc;
				res.hit_valid  = 1'b1;
				res.hit_number = hc_inc;
				res.hit_time   = el_b_wide[TIME_W-1:0];
				if (hc_inc >= limit) begin
					ec_n = END_HIT_LIMIT;
				end else begin
					bl_n = cfg.blank_ticks;
				end
			end else if (item.tick && bl_b != 8'd0) begin
				bl_n = bl_b - 8'd1;
			end
			// A hit that ends the run also swallows the tick of its item.
			if (item.tick && ec_n == END_RUNNING) begin
				el_n = el_inc;
				il_n = il_dec;
				if (il_dec == 16'd0) begin
					ec_n = END_IDLE;
				end else begin
					if (bk_dec == 8'd0) begin
						bk_n  = cfg.blink_period;
						dot_n = ~dot_b;
					end else begin
						bk_n = bk_dec;
					end
					sh_n = sh_shift;
					fh_n = fh_shift;
					if ((start_det || fwd_det) && stop_ok) begin
						ec_n = start_det ? END_START : END_FORWARD;
					end
				end
			end
		end
		res.elapsed_ticks = el_n_wide[TIME_W-1:0];
		res.dot_lit       = dot_n;
		res.end_cause     = ec_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			el_q  <= '0;
			hc_q  <= '0;
			bl_q  <= '0;
			il_q  <= IDLE_LIMIT_RST;
			bk_q  <= BLINK_PERIOD_RST;
			dot_q <= 1'b1;
			sh_q  <= HIST_IDLE;
			fh_q  <= HIST_IDLE;
			ec_q  <= END_RUNNING;
		end else if (step) begin
			el_q  <= el_n;
			hc_q  <= hc_n;
			bl_q  <= bl_n;
			il_q  <= il_n;
			bk_q  <= bk_n;
			dot_q <= dot_n;
			sh_q  <= sh_n;
			fh_q  <= fh_n;
			ec_q  <= ec_n;
		end
	end

endmodule
